/* hw/rtl/usp_pkg.sv */
// ----------------------------------------------------------------------------
// usp_pkg - shared types and constants for the URL splitter
// Parse state, result record, phase and error codes, character constants.
// ----------------------------------------------------------------------------
package usp_pkg;

    localparam int MAX_LEN = 4096;
    localparam int LEN_W   = 13;
    localparam int ACC_W   = 17;
    localparam int PORT_W  = 16;

    localparam logic [ACC_W-1:0] PORT_SAT = ACC_W'(65536);
    localparam logic [ACC_W-1:0] PORT_MAX = ACC_W'(65535);

    // port flag bit positions
    localparam int PF_SIGN   = 0;
    localparam int PF_DIGITS = 1;
    localparam int PF_NEG    = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    typedef enum logic [3:0] {
        PH_SCHEME, PH_SEP1, PH_SEP2, PH_HOST, PH_PORT_WS, PH_PORT_DIG,
        PH_PATH_FIRST, PH_PATH, PH_DONE_DEF, PH_DONE_PATH, PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE, ERR_MALFORMED, ERR_TOO_LONG
    } err_t;

    typedef struct packed {
        logic [LEN_W-1:0] position;
        phase_t           phase;
        logic [LEN_W-1:0] scheme_run_len;
        logic             host_class_ok;
        logic [LEN_W-1:0] host_begin;
        logic [LEN_W-1:0] host_length;
        logic [ACC_W-1:0] port_accum;
        logic [2:0]       port_flags;
        logic [LEN_W-1:0] path_begin;
        logic [LEN_W-1:0] last_slash;
        err_t             error_flag;
    } state_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              has_scheme;
        logic [LEN_W-1:0]  scheme_len;
        logic [LEN_W-1:0]  host_start;
        logic [LEN_W-1:0]  host_len;
        logic              has_port;
        logic [PORT_W-1:0] port_number;
        logic              path_default;
        logic [LEN_W-1:0]  path_start;
        logic [LEN_W-1:0]  path_len;
        logic [LEN_W-1:0]  name_start;
    } result_t;

    localparam state_t STATE_INIT = '{
        position:       '0,
        phase:          PH_SCHEME,
        scheme_run_len: '0,
        host_class_ok:  1'b1,
        host_begin:     '0,
        host_length:    '0,
        port_accum:     '0,
        port_flags:     '0,
        path_begin:     '0,
        last_slash:     '0,
        error_flag:     ERR_NONE
    };

endpackage

/* hw/rtl/usp_step.sv */
// ----------------------------------------------------------------------------
// usp_step - per-byte parse step
// Next parse state and the finished result record for one input byte.
// ----------------------------------------------------------------------------
module usp_step (
    input  usp_pkg::state_t  state_cur,
    input  logic [7:0]       char_code,
    output usp_pkg::state_t  state_next,
    output usp_pkg::result_t result_next
);
    import usp_pkg::*;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_digit(c) || ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic is_host_char(logic [7:0] c);
        return is_alnum(c) || (c == CH_MINUS) || (c == CH_DOT);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic state_t go_fail(state_t s);
        state_t r;
        r            = s;
        r.error_flag = ERR_MALFORMED;
        r.phase      = PH_FAIL;
        return r;
    endfunction

    function automatic state_t path_open(state_t s, logic [7:0] c);
        state_t r;
        r            = s;
        r.path_begin = s.position;
        if (c == CH_NUL) begin
            if (s.host_length == '0) begin
                r = go_fail(r);
            end else begin
                r.phase = PH_DONE_DEF;
            end
        end else if (c == CH_SLASH) begin
            r.last_slash = s.position;
            r.phase      = PH_PATH_FIRST;
        end else begin
            r = go_fail(r);
        end
        return r;
    endfunction

    function automatic state_t after_host(state_t s, logic [7:0] c);
        state_t r;
        r = s;
        if (c == CH_COLON) begin
            if (s.host_length == '0) begin
                r = go_fail(r);
            end else begin
                r.phase      = PH_PORT_WS;
                r.port_accum = '0;
                r.port_flags = '0;
            end
        end else begin
            r = path_open(s, c);
        end
        return r;
    endfunction

    // accum * 10 + digit as two shifts and adds, saturated
    function automatic state_t port_add(state_t s, logic [7:0] c);
        state_t      r;
        logic [19:0] acc;
        logic [19:0] sum;
        r   = s;
        acc = {3'b000, s.port_accum};
        sum = (acc << 3) + (acc << 1) + {16'b0, c[3:0]};
        if (sum > {3'b000, PORT_SAT}) begin
            r.port_accum = PORT_SAT;
        end else begin
            r.port_accum = sum[ACC_W-1:0];
        end
        r.port_flags[PF_DIGITS] = 1'b1;
        return r;
    endfunction

    function automatic state_t port_ws(state_t s, logic [7:0] c);
        state_t r;
        r = s;
        if (is_space(c)) begin
            r = s;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            r.port_flags[PF_SIGN] = 1'b1;
            if (c == CH_MINUS) begin
                r.port_flags[PF_NEG] = 1'b1;
            end
            r.phase = PH_PORT_DIG;
        end else if (is_digit(c)) begin
            r       = port_add(s, c);
            r.phase = PH_PORT_DIG;
        end else begin
            r = go_fail(s);
        end
        return r;
    endfunction

    function automatic state_t port_dig(state_t s, logic [7:0] c);
        state_t r;
        r = s;
        if (is_digit(c)) begin
            r = port_add(s, c);
        end else if (!s.port_flags[PF_DIGITS]
                     || (s.port_flags[PF_NEG] && (s.port_accum != '0))
                     || (s.port_accum > PORT_MAX)) begin
            r = go_fail(s);
        end else begin
            r            = s;
            r.port_flags = 3'b010;
            r            = path_open(r, c);
        end
        return r;
    endfunction

    function automatic state_t feed(state_t s, logic [7:0] c);
        state_t r;
        state_t d;
        r = s;
        // the scanned run reinterpreted as the host
        d                = s;
        d.host_begin     = '0;
        d.host_length    = s.scheme_run_len;
        d.scheme_run_len = '0;
        unique case (s.phase)
            PH_SCHEME: begin
                if (is_alnum(c) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_DOT)) begin
                    r.scheme_run_len = s.scheme_run_len + 1'b1;
                    if (!is_host_char(c)) begin
                        r.host_class_ok = 1'b0;
                    end
                end else if ((c == CH_COLON) && (s.scheme_run_len != '0)) begin
                    r.phase = PH_SEP1;
                end else if (!s.host_class_ok) begin
                    r = go_fail(s);
                end else begin
                    r = after_host(d, c);
                end
            end
            PH_SEP1: begin
                if (c == CH_SLASH) begin
                    r.phase = PH_SEP2;
                end else if (!s.host_class_ok) begin
                    r = go_fail(s);
                end else begin
                    d.phase      = PH_PORT_WS;
                    d.port_accum = '0;
                    d.port_flags = '0;
                    r            = port_ws(d, c);
                end
            end
            PH_SEP2: begin
                if (c == CH_SLASH) begin
                    r.phase       = PH_HOST;
                    r.host_begin  = s.position + 1'b1;
                    r.host_length = '0;
                end else begin
                    r = go_fail(s);
                end
            end
            PH_HOST: begin
                if (is_host_char(c)) begin
                    r.host_length = s.host_length + 1'b1;
                end else if (s.host_length == '0) begin
                    r = go_fail(s);
                end else begin
                    r = after_host(s, c);
                end
            end
            PH_PORT_WS:  r = port_ws(s, c);
            PH_PORT_DIG: r = port_dig(s, c);
            PH_PATH_FIRST: begin
                if (c == CH_NUL) begin
                    r.phase = PH_DONE_DEF;
                end else begin
                    r.phase = PH_PATH;
                    if (c == CH_SLASH) begin
                        r.last_slash = s.position;
                    end
                end
            end
            PH_PATH: begin
                if (c == CH_NUL) begin
                    r.phase = PH_DONE_PATH;
                end else if (c == CH_SLASH) begin
                    r.last_slash = s.position;
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    state_t fed;
    state_t fin;
    logic   def_path;

    assign fed      = feed(state_cur, char_code);
    assign fin      = (state_cur.error_flag == ERR_NONE) ? fed : state_cur;
    assign def_path = (fin.phase == PH_DONE_DEF);

    always_comb begin
        state_next  = state_cur;
        result_next = '0;
        if (char_code != CH_NUL) begin
            if (state_cur.position >= LEN_W'(MAX_LEN)) begin
                state_next.error_flag = ERR_TOO_LONG;
            end else begin
                state_next          = fin;
                state_next.position = state_cur.position + 1'b1;
            end
        end else begin
            state_next = STATE_INIT;
            if (fin.error_flag == ERR_TOO_LONG) begin
                result_next.status = ST_TOO_LONG;
            end else if ((fin.error_flag != ERR_NONE)
                         || ((fin.phase != PH_DONE_DEF) && (fin.phase != PH_DONE_PATH))) begin
                result_next.status = ST_MALFORMED;
            end else begin
                result_next.status       = ST_OK;
                result_next.has_scheme   = (fin.scheme_run_len != '0);
                result_next.scheme_len   = fin.scheme_run_len;
                result_next.host_start   = fin.host_begin;
                result_next.host_len     = fin.host_length;
                result_next.has_port     = fin.port_flags[PF_DIGITS];
                result_next.port_number  = fin.port_flags[PF_DIGITS]
                                         ? fin.port_accum[PORT_W-1:0] : '0;
                result_next.path_default = def_path;
                result_next.path_start   = fin.path_begin;
                result_next.path_len     = def_path ? '0 : (fin.position - fin.path_begin);
                result_next.name_start   = def_path ? fin.position : (fin.last_slash + 1'b1);
            end
        end
    end

endmodule

/* hw/rtl/url_splitter.sv */
// ----------------------------------------------------------------------------
// url_splitter - streaming URL splitter
// Splits a byte-serial URL into scheme, host, port and path descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready/s_char_code) carries one URL byte per
//   transaction. A zero byte ends the string; it produces exactly one result
//   transaction on the output channel (m_valid/m_ready/m_*), while every
//   other byte produces none. The result holds the status (ok, malformed,
//   longer than 4096 bytes), the scheme length, offsets and lengths of host
//   and path, the port number and the offset of the final path name.
//   Timing: a byte sits in the input register, where one pass of the parse
//   step updates the state; the result goes from the step into the output
//   register when the step consumes the terminating byte, which waits only
//   while an earlier result still occupies the output register.
//   Throughput: one byte per cycle while no terminator waits for the output
//   register; the parse step is combinational and reads the input register.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to the start of a string. After each result the parser restarts.
//   When the receiver stalls, the result stays in the output register; non-
//   terminating bytes keep flowing, and only a second terminator waits.
// ----------------------------------------------------------------------------
module url_splitter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_char_code,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic                       m_has_scheme,
    output logic [usp_pkg::LEN_W-1:0]  m_scheme_len,
    output logic [usp_pkg::LEN_W-1:0]  m_host_start,
    output logic [usp_pkg::LEN_W-1:0]  m_host_len,
    output logic                       m_has_port,
    output logic [usp_pkg::PORT_W-1:0] m_port_number,
    output logic                       m_path_default,
    output logic [usp_pkg::LEN_W-1:0]  m_path_start,
    output logic [usp_pkg::LEN_W-1:0]  m_path_len,
    output logic [usp_pkg::LEN_W-1:0]  m_name_start
);
    import usp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    result_reg;
    result_t    result_next;
    logic       m_valid_reg;

    logic out_free;
    logic is_term;
    logic advance;

    // Parse step: pure logic between input register and result register
    usp_step u_step (
        .state_cur   (state_reg),
        .char_code   (in_char_reg),
        .state_next  (state_next),
        .result_next (result_next)
    );

    // Output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign is_term  = (in_char_reg == CH_NUL);
    // Ordinary bytes always advance; a terminator needs the output slot
    assign advance  = in_valid_reg && (!is_term || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= STATE_INIT;
        end else begin
            // Refill the input register whenever it empties
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (s_valid && s_ready) begin
                in_char_reg <= s_char_code;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            // Load a result on a terminator, otherwise drop it once taken
            if (advance && is_term) begin
                m_valid_reg <= 1'b1;
                result_reg  <= result_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = result_reg.status;
    assign m_has_scheme   = result_reg.has_scheme;
    assign m_scheme_len   = result_reg.scheme_len;
    assign m_host_start   = result_reg.host_start;
    assign m_host_len     = result_reg.host_len;
    assign m_has_port     = result_reg.has_port;
    assign m_port_number  = result_reg.port_number;
    assign m_path_default = result_reg.path_default;
    assign m_path_start   = result_reg.path_start;
    assign m_path_len     = result_reg.path_len;
    assign m_name_start   = result_reg.name_start;

    // A consumed terminator restarts the parser and presents a result
    a_term_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_term) |=> (m_valid_reg && (state_reg.position == '0)
                                  && (state_reg.phase == PH_SCHEME)))
        else $error("terminator did not restart the parser");

    // Failed results carry no descriptors
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status != ST_OK)) |->
            (!m_has_scheme && (m_host_len == '0) && !m_has_port
             && (m_port_number == '0) && !m_path_default && (m_path_len == '0)))
        else $error("failed result carries descriptor fields");

    // An explicit path starts with a slash, so the name lies past it
    a_path_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status == ST_OK) && !m_path_default) |->
            ((m_path_len != '0) && (m_name_start > m_path_start)))
        else $error("explicit path with bad length or name offset");

    // Default root: empty path, empty name at or just past the path offset
    a_path_default: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status == ST_OK) && m_path_default) |->
            ((m_path_len == '0) && (m_name_start >= m_path_start)))
        else $error("default path result inconsistent");

    // A port is only reported after a host
    a_port_host: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status == ST_OK) && m_has_port) |-> (m_host_len != '0))
        else $error("port reported without host");

endmodule
